[rtl/rgb_box_colour_classifier_defines.svh]
// assertion macros shared by the classifier checker
// no dependencies; the checker supplies clk and rst
`ifndef RGB_BOX_COLOUR_CLASSIFIER_DEFINES_SVH
`define RGB_BOX_COLOUR_CLASSIFIER_DEFINES_SVH

// condition that must hold at every clock edge outside reset
`define RBCC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rbcc check failed");

// consequence that must hold in the cycle after the antecedent, outside reset
`define RBCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbcc check failed");

// consequence in the following cycle, also checked across reset
`define RBCC_ASSERT_NEXT_ANY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rbcc check failed");

`endif

[rtl/rbcc_pkg.sv]
// types, class codes and the box table of the colour classifier
// no dependencies
package rbcc_pkg;

  localparam int COUNT_W  = 16;   // width of one sensor count
  localparam int BOUND_W  = 9;    // width of a normalized bound (max 275)
  localparam int LIMIT_W  = 17;   // width of a raw clear limit (max 65537)
  localparam int PROD_W   = COUNT_W + BOUND_W;
  localparam int NUM_BOXES = 8;

  typedef enum logic [2:0] {
    CLASS_NONE   = 3'd0,
    CLASS_RED    = 3'd1,
    CLASS_GREEN  = 3'd2,
    CLASS_YELLOW = 3'd3,
    CLASS_WHITE  = 3'd4,
    CLASS_BLACK  = 3'd5,
    CLASS_BLUE   = 3'd6,
    CLASS_ORANGE = 3'd7
  } colour_class_t;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [BOUND_W-1:0] bound_t;
  typedef logic [LIMIT_W-1:0] limit_t;

  // one reading as it travels through the pipe
  typedef struct packed {
    count_t clear_count;
    count_t red_count;
    count_t green_count;
    count_t blue_count;
  } reading_t;

  // strict bounds of one box, normalized channels and raw clear
  typedef struct packed {
    bound_t        rlo;
    bound_t        rhi;
    bound_t        glo;
    bound_t        ghi;
    bound_t        blo;
    bound_t        bhi;
    limit_t        clo;
    limit_t        chi;
    colour_class_t cls;
  } box_t;

  // boxes in test order, first hit wins
  localparam box_t BOXES [NUM_BOXES] = '{
    '{9'd175, 9'd205, 9'd35,  9'd55,  9'd35,  9'd60,
      17'd0,     17'd65537, CLASS_RED},
    '{9'd35,  9'd75,  9'd115, 9'd145, 9'd45,  9'd70,
      17'd0,     17'd65537, CLASS_GREEN},
    '{9'd80,  9'd95,  9'd110, 9'd130, 9'd30,  9'd50,
      17'd0,     17'd65537, CLASS_GREEN},
    '{9'd115, 9'd210, 9'd100, 9'd190, 9'd35,  9'd70,
      17'd50000, 17'd65537, CLASS_YELLOW},
    '{9'd95,  9'd240, 9'd85,  9'd275, 9'd95,  9'd125,
      17'd65000, 17'd65537, CLASS_WHITE},
    '{9'd50,  9'd115, 9'd80,  9'd115, 9'd50,  9'd105,
      17'd4000,  17'd9000,  CLASS_BLACK},
    '{9'd25,  9'd55,  9'd75,  9'd95,  9'd115, 9'd140,
      17'd0,     17'd65537, CLASS_BLUE},
    '{9'd150, 9'd175, 9'd55,  9'd75,  9'd30,  9'd45,
      17'd0,     17'd65537, CLASS_ORANGE}
  };

endpackage

[rtl/rbcc_box_test.sv]
// strict containment test of one reading against one colour box
// depends on rbcc_pkg
module rbcc_box_test (
  input  rbcc_pkg::reading_t reading,
  input  rbcc_pkg::box_t     box,
  output logic               hit
);

  logic [rbcc_pkg::PROD_W-1:0]  clear_w;
  logic [rbcc_pkg::PROD_W-1:0]  red_s;
  logic [rbcc_pkg::PROD_W-1:0]  green_s;
  logic [rbcc_pkg::PROD_W-1:0]  blue_s;
  logic [rbcc_pkg::PROD_W-1:0]  rlo_p, rhi_p, glo_p, ghi_p, blo_p, bhi_p;
  logic [rbcc_pkg::LIMIT_W-1:0] clear_l;
  logic                         red_in, green_in, blue_in, clear_in;

  // channel * 255 as (channel << 8) - channel
  assign clear_w = rbcc_pkg::PROD_W'(reading.clear_count);
  assign red_s   = (rbcc_pkg::PROD_W'(reading.red_count) << 8)
                   - rbcc_pkg::PROD_W'(reading.red_count);
  assign green_s = (rbcc_pkg::PROD_W'(reading.green_count) << 8)
                   - rbcc_pkg::PROD_W'(reading.green_count);
  assign blue_s  = (rbcc_pkg::PROD_W'(reading.blue_count) << 8)
                   - rbcc_pkg::PROD_W'(reading.blue_count);

  // bound * clear, bounds are constants so these reduce to adders
  assign rlo_p = rbcc_pkg::PROD_W'(box.rlo) * clear_w;
  assign rhi_p = rbcc_pkg::PROD_W'(box.rhi) * clear_w;
  assign glo_p = rbcc_pkg::PROD_W'(box.glo) * clear_w;
  assign ghi_p = rbcc_pkg::PROD_W'(box.ghi) * clear_w;
  assign blo_p = rbcc_pkg::PROD_W'(box.blo) * clear_w;
  assign bhi_p = rbcc_pkg::PROD_W'(box.bhi) * clear_w;

  // strict window compares
  assign red_in   = (red_s > rlo_p) && (red_s < rhi_p);
  assign green_in = (green_s > glo_p) && (green_s < ghi_p);
  assign blue_in  = (blue_s > blo_p) && (blue_s < bhi_p);

  assign clear_l  = rbcc_pkg::LIMIT_W'(reading.clear_count);
  assign clear_in = (clear_l > box.clo) && (clear_l < box.chi);

  assign hit = red_in && green_in && blue_in && clear_in;

endmodule

[rtl/rbcc_prio.sv]
// first-hit selection over the box test results
// depends on rbcc_pkg
module rbcc_prio (
  input  logic [rbcc_pkg::NUM_BOXES-1:0] hits,
  output rbcc_pkg::colour_class_t        cls
);

  // walk from the last box down so the earliest hit is kept
  always_comb begin
    cls = rbcc_pkg::CLASS_NONE;
    for (int i = rbcc_pkg::NUM_BOXES - 1; i >= 0; i--) begin
      if (hits[i]) begin
        cls = rbcc_pkg::BOXES[i].cls;
      end
    end
  end

endmodule

[rtl/rgb_box_colour_classifier.sv]
// Colour box classifier for one colour sensor reading per beat.
//
// Input channel: in_valid / in_stall with clear_count, red_count,
// green_count and blue_count. A beat is taken on a rising edge with
// in_valid high and in_stall low.
// Output channel: out_valid / out_stall with colour_class (0 undetected,
// 1 red, 2 green, 3 yellow, 4 white, 5 black, 6 blue, 7 orange).
//
// Pipeline: input register, box-hit register, result register. A result is
// shown from the result register; one beat per cycle while out_stall is low.
// The eight box tests run in parallel on constant cross-multiplies; the
// result register limits the rate to one class per cycle.
// Receiver stall: each stage holds while full and blocked; bubbles are
// squeezed out, so in_stall rises only once all three stages are full and
// out_stall is high. Results are never dropped or repeated.
// A zero clear count always gives undetected.
// Reset (rst, synchronous): all stages empty; no configuration exists.
// Depends on rbcc_pkg, rbcc_box_test and rbcc_prio.
module rgb_box_colour_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] clear_count,
  input  logic [15:0] red_count,
  input  logic [15:0] green_count,
  input  logic [15:0] blue_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  colour_class
);

  logic                          s1_valid;
  rbcc_pkg::reading_t            s1_reading;
  logic                          s2_valid;
  logic [rbcc_pkg::NUM_BOXES-1:0] s2_hits;
  logic [rbcc_pkg::NUM_BOXES-1:0] s2_hits_next;
  logic                          res_valid;
  rbcc_pkg::colour_class_t       res_class;
  rbcc_pkg::colour_class_t       res_class_next;
  logic                          res_ready;
  logic                          s2_ready;
  logic                          s1_ready;
  logic                          in_take;
  logic [rbcc_pkg::NUM_BOXES-1:0] box_hits;

  // per-stage ready, a stage moves when empty or when its successor moves
  assign res_ready = !res_valid || !out_stall;
  assign s2_ready  = !s2_valid || res_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_take   = in_valid && s1_ready;

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (res_ready) res_valid <= s2_valid;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_reading <= '{clear_count, red_count, green_count, blue_count};
    end
  end

  // parallel box tests
  for (genvar b = 0; b < rbcc_pkg::NUM_BOXES; b++) begin : g_box
    rbcc_box_test u_box (
      .reading (s1_reading),
      .box     (rbcc_pkg::BOXES[b]),
      .hit     (box_hits[b])
    );
  end

  // a zero clear count never classifies
  assign s2_hits_next = (s1_reading.clear_count != '0) ? box_hits : '0;

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_hits <= s2_hits_next;
    end
  end

  // first hit wins
  rbcc_prio u_prio (
    .hits (s2_hits),
    .cls  (res_class_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (res_ready && s2_valid) begin
      res_class <= res_class_next;
    end
  end

  assign out_valid    = res_valid;
  assign colour_class = res_class;

endmodule

[rtl/rbcc_checker.sv]
// port-level checks of the colour classifier, bound to the top level
// depends on rgb_box_colour_classifier_defines.svh
`include "rgb_box_colour_classifier_defines.svh"

module rbcc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] colour_class
);

  // a blocked result stays up
  `RBCC_ASSERT_NEXT(a_out_valid_holds, out_valid && out_stall, out_valid)

  // a blocked result keeps its class
  `RBCC_ASSERT_NEXT(a_out_class_holds, out_valid && out_stall, $stable(colour_class))

  // input backs up only behind a blocked result
  `RBCC_ASSERT_ALWAYS(a_stall_cause, !in_stall || (out_valid && out_stall))

  // reset empties the pipe
  `RBCC_ASSERT_NEXT_ANY(a_reset_empty, rst, !out_valid && !in_stall)

endmodule

bind rgb_box_colour_classifier rbcc_checker u_rbcc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .colour_class (colour_class)
);

[tb/sv/rgb_box_colour_classifier_tb.sv]
// self-checking testbench for the rgb box colour classifier
// depends on rbcc_pkg and rgb_box_colour_classifier; predicts classes from its own box table or a typed class
module rgb_box_colour_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_DIRECTED   = 24;
  localparam int ITEMS_PER_LEG  = 175;
  localparam int LONG_HOLD      = 80;
  localparam int PRESSURE_ITEMS = 24;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  // strict limits of one box: normalized channels and raw clear
  typedef struct packed {
    logic [8:0]              rlo;
    logic [8:0]              rhi;
    logic [8:0]              glo;
    logic [8:0]              ghi;
    logic [8:0]              blo;
    logic [8:0]              bhi;
    logic [16:0]             clo;
    logic [16:0]             chi;
    rbcc_pkg::colour_class_t cls;
  } box_bounds_t;

  // one directed reading, with a hand-typed class where it is obvious
  typedef struct packed {
    rbcc_pkg::count_t        clear_cnt;
    rbcc_pkg::count_t        red_cnt;
    rbcc_pkg::count_t        green_cnt;
    rbcc_pkg::count_t        blue_cnt;
    logic                    typed;
    rbcc_pkg::colour_class_t typed_cls;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] clear_count = '0;
  logic [15:0] red_count = '0;
  logic [15:0] green_count = '0;
  logic [15:0] blue_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  colour_class;

  // travels with the beat: use the typed class instead of the predictor
  logic                    cur_typed = 1'b0;
  rbcc_pkg::colour_class_t cur_typed_cls = rbcc_pkg::CLASS_NONE;

  rbcc_pkg::colour_class_t pending_classes[$];
  int            mismatch_count = 0;
  int            result_idx = 0;
  int            idle_cycles = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            hold_req = 0;
  int            hold_seen = 0;
  int            hold_left = 0;

  rgb_box_colour_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .clear_count  (clear_count),
    .red_count    (red_count),
    .green_count  (green_count),
    .blue_count   (blue_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .colour_class (colour_class)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // boxes in test order, first hit wins
  function automatic box_bounds_t box_bounds(int idx);
    box_bounds_t bx;
    case (idx)
      0: bx = {9'd175, 9'd205, 9'd35, 9'd55, 9'd35, 9'd60, 17'd0, 17'd65537,
               rbcc_pkg::CLASS_RED};
      1: bx = {9'd35, 9'd75, 9'd115, 9'd145, 9'd45, 9'd70, 17'd0, 17'd65537,
               rbcc_pkg::CLASS_GREEN};
      2: bx = {9'd80, 9'd95, 9'd110, 9'd130, 9'd30, 9'd50, 17'd0, 17'd65537,
               rbcc_pkg::CLASS_GREEN};
      3: bx = {9'd115, 9'd210, 9'd100, 9'd190, 9'd35, 9'd70, 17'd50000, 17'd65537,
               rbcc_pkg::CLASS_YELLOW};
      4: bx = {9'd95, 9'd240, 9'd85, 9'd275, 9'd95, 9'd125, 17'd65000, 17'd65537,
               rbcc_pkg::CLASS_WHITE};
      5: bx = {9'd50, 9'd115, 9'd80, 9'd115, 9'd50, 9'd105, 17'd4000, 17'd9000,
               rbcc_pkg::CLASS_BLACK};
      6: bx = {9'd25, 9'd55, 9'd75, 9'd95, 9'd115, 9'd140, 17'd0, 17'd65537,
               rbcc_pkg::CLASS_BLUE};
      default: bx = {9'd150, 9'd175, 9'd55, 9'd75, 9'd30, 9'd45, 17'd0, 17'd65537,
                     rbcc_pkg::CLASS_ORANGE};
    endcase
    return bx;
  endfunction

  // channel*255 strictly between lo*clear and hi*clear, exact in 64 bits
  function automatic bit norm_in_range(rbcc_pkg::count_t ch, rbcc_pkg::count_t c,
                                       logic [8:0] lo, logic [8:0] hi);
    longint unsigned scaled;
    longint unsigned lo_lim;
    longint unsigned hi_lim;
    scaled = 64'(ch);
    scaled = scaled * 255;
    lo_lim = 64'(lo);
    lo_lim = lo_lim * c;
    hi_lim = 64'(hi);
    hi_lim = hi_lim * c;
    return (scaled > lo_lim) && (scaled < hi_lim);
  endfunction

  // walk boxes from last to first so the first hit is what remains
  function automatic rbcc_pkg::colour_class_t classify_reading(rbcc_pkg::count_t c,
                                                               rbcc_pkg::count_t r,
                                                               rbcc_pkg::count_t g,
                                                               rbcc_pkg::count_t b);
    rbcc_pkg::colour_class_t found;
    box_bounds_t             bx;
    found = rbcc_pkg::CLASS_NONE;
    if (c != 0) begin
      for (int i = rbcc_pkg::NUM_BOXES - 1; i >= 0; i--) begin
        bx = box_bounds(i);
        if (norm_in_range(r, c, bx.rlo, bx.rhi) && norm_in_range(g, c, bx.glo, bx.ghi) &&
            norm_in_range(b, c, bx.blo, bx.bhi) && c > bx.clo && c < bx.chi) begin
          found = bx.cls;
        end
      end
    end
    return found;
  endfunction

  // directed readings: extremes, every class, strict edges of bounds and clear limits
  function automatic stim_row_t directed_row(int idx);
    stim_row_t row;
    case (idx)
      0:  row = {16'd0, 16'd0, 16'd0, 16'd0, 1'b1, rbcc_pkg::CLASS_NONE};
      1:  row = {16'd0, 16'hffff, 16'hffff, 16'hffff, 1'b1, rbcc_pkg::CLASS_NONE};
      2:  row = {16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1, rbcc_pkg::CLASS_NONE};
      3:  row = {16'hffff, 16'd0, 16'd0, 16'd0, 1'b1, rbcc_pkg::CLASS_NONE};
      4:  row = {16'd1, 16'hffff, 16'hffff, 16'hffff, 1'b0, rbcc_pkg::CLASS_NONE};
      5:  row = {16'd2550, 16'd1900, 16'd450, 16'd450, 1'b0, rbcc_pkg::CLASS_NONE};
      6:  row = {16'd2550, 16'd550, 16'd1300, 16'd600, 1'b0, rbcc_pkg::CLASS_NONE};
      7:  row = {16'd2550, 16'd870, 16'd1200, 16'd400, 1'b0, rbcc_pkg::CLASS_NONE};
      8:  row = {16'd51000, 16'd30000, 16'd30000, 16'd10000, 1'b0, rbcc_pkg::CLASS_NONE};
      9:  row = {16'd65280, 16'd51200, 16'd51200, 16'd28160, 1'b0, rbcc_pkg::CLASS_NONE};
      10: row = {16'd5100, 16'd1600, 16'd2000, 16'd1600, 1'b0, rbcc_pkg::CLASS_NONE};
      11: row = {16'd2550, 16'd400, 16'd850, 16'd1300, 1'b0, rbcc_pkg::CLASS_NONE};
      12: row = {16'd2550, 16'd1600, 16'd650, 16'd400, 1'b0, rbcc_pkg::CLASS_NONE};
      13: row = {16'd2550, 16'd1750, 16'd450, 16'd450, 1'b0, rbcc_pkg::CLASS_NONE};
      14: row = {16'd2550, 16'd2050, 16'd450, 16'd450, 1'b0, rbcc_pkg::CLASS_NONE};
      15: row = {16'd50000, 16'd29412, 16'd29412, 16'd9804, 1'b0, rbcc_pkg::CLASS_NONE};
      16: row = {16'd50001, 16'd29412, 16'd29412, 16'd9804, 1'b0, rbcc_pkg::CLASS_NONE};
      17: row = {16'd4000, 16'd1412, 16'd1569, 16'd1255, 1'b0, rbcc_pkg::CLASS_NONE};
      18: row = {16'd4001, 16'd1412, 16'd1569, 16'd1255, 1'b0, rbcc_pkg::CLASS_NONE};
      19: row = {16'd9000, 16'd3176, 16'd3529, 16'd2824, 1'b0, rbcc_pkg::CLASS_NONE};
      20: row = {16'd8999, 16'd3176, 16'd3529, 16'd2824, 1'b0, rbcc_pkg::CLASS_NONE};
      21: row = {16'd65000, 16'd50980, 16'd50980, 16'd28039, 1'b0, rbcc_pkg::CLASS_NONE};
      22: row = {16'd65001, 16'd50981, 16'd50981, 16'd28040, 1'b0, rbcc_pkg::CLASS_NONE};
      default: row = {16'd65001, 16'd50981, 16'hffff, 16'd28040, 1'b0,
                      rbcc_pkg::CLASS_NONE};
    endcase
    return row;
  endfunction

  // raw count for a normalized window, either inside it or right at one bound
  function automatic rbcc_pkg::count_t pick_channel(rbcc_pkg::count_t c, logic [8:0] lo,
                                                    logic [8:0] hi, bit at_bound);
    longint lo_n;
    longint hi_n;
    longint v;
    int     step;
    lo_n = longint'(lo);
    lo_n = lo_n * c / 255;
    hi_n = longint'(hi);
    hi_n = hi_n * c / 255;
    step = $urandom_range(0, 2);
    if (at_bound) begin
      v = ($urandom_range(0, 1) ? hi_n : lo_n) + step - 1;
    end else begin
      v = $urandom_range(lo_n, hi_n + 1);
    end
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return rbcc_pkg::count_t'(v);
  endfunction

  // mostly readings aimed at a box, some at its edges, some pure noise
  task automatic gen_random_reading(output rbcc_pkg::count_t c, output rbcc_pkg::count_t r,
                                    output rbcc_pkg::count_t g, output rbcc_pkg::count_t b);
    int          mode;
    int          sel;
    bit          at_bound;
    box_bounds_t bx;
    int unsigned c_hi;
    mode = $urandom_range(0, 99);
    if (mode < 15) begin
      c = rbcc_pkg::count_t'($urandom_range(0, 65535));
      r = rbcc_pkg::count_t'($urandom_range(0, 65535));
      g = rbcc_pkg::count_t'($urandom_range(0, 65535));
      b = rbcc_pkg::count_t'($urandom_range(0, 65535));
    end else begin
      bx = box_bounds($urandom_range(0, rbcc_pkg::NUM_BOXES - 1));
      c_hi = (bx.chi > 17'd65535) ? 32'd65535 : 32'(bx.chi - 17'd1);
      if (mode < 30) begin
        c = rbcc_pkg::count_t'(255 * $urandom_range(1, 257));
      end else if (mode < 40) begin
        sel = $urandom_range(0, 3);
        case (sel)
          0: c = rbcc_pkg::count_t'(bx.clo);
          1: c = rbcc_pkg::count_t'(bx.clo + 17'd1);
          2: c = rbcc_pkg::count_t'(c_hi);
          default: c = (bx.chi > 17'd65535) ? 16'hffff : rbcc_pkg::count_t'(bx.chi);
        endcase
      end else begin
        c = rbcc_pkg::count_t'($urandom_range(32'(bx.clo) + 1, c_hi));
      end
      at_bound = (mode >= 25) && (mode < 50);
      r = pick_channel(c, bx.rlo, bx.rhi, at_bound && $urandom_range(0, 1));
      g = pick_channel(c, bx.glo, bx.ghi, at_bound && $urandom_range(0, 1));
      b = pick_channel(c, bx.blo, bx.bhi, at_bound && $urandom_range(0, 1));
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s, got class %0d, expected %0d",
             result_idx, what, got, want);
    mismatch_count++;
  endtask

  // append one expected class behind the ones already waiting
  task automatic queue_expected(input rbcc_pkg::colour_class_t cls);
    pending_classes = {pending_classes, cls};
  endtask

  // offer one beat from a falling edge, return at the falling edge after it is taken
  task automatic send_reading(input rbcc_pkg::count_t c, input rbcc_pkg::count_t r,
                              input rbcc_pkg::count_t g, input rbcc_pkg::count_t b,
                              input logic typed, input rbcc_pkg::colour_class_t typed_cls);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    clear_count   <= c;
    red_count     <= r;
    green_count   <= g;
    blue_count    <= b;
    cur_typed     <= typed;
    cur_typed_cls <= typed_cls;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= stall_pct;
  endtask

  task automatic send_random_readings(input int n);
    rbcc_pkg::count_t c, r, g, b;
    for (int i = 0; i < n; i++) begin
      gen_random_reading(c, r, g, b);
      send_reading(c, r, g, b, 1'b0, rbcc_pkg::CLASS_NONE);
    end
  endtask

  // receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // check result beats, predict input beats, watch for a hang
  always @(posedge clk) begin : check_results
    rbcc_pkg::colour_class_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_classes.size() == 0) begin
          report_mismatch("result beat with nothing pending", colour_class, -1);
        end else begin
          want = pending_classes.pop_front();
          if (colour_class !== want) begin
            report_mismatch("wrong colour_class", colour_class, want);
          end
        end
        result_idx++;
      end
      if (in_valid && !in_stall) begin
        if (cur_typed) begin
          queue_expected(cur_typed_cls);
        end else begin
          queue_expected(classify_reading(clear_count, red_count, green_count, blue_count));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // reset, directed table, random legs under each idling pattern, pressure, drain
  initial begin : stimulus
    stim_row_t row;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_idling(0, 0);
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = directed_row(i);
      send_reading(row.clear_cnt, row.red_cnt, row.green_cnt, row.blue_cnt, row.typed,
                   row.typed_cls);
    end

    for (int leg = 0; leg < 2; leg++) begin
      set_idling(0, 0);
      send_random_readings(ITEMS_PER_LEG);
      set_idling(65, 0);
      send_random_readings(ITEMS_PER_LEG);
      set_idling(0, 65);
      send_random_readings(ITEMS_PER_LEG);
      set_idling(15, 15);
      send_random_readings(ITEMS_PER_LEG);

      // long receiver hold-off while beats keep coming, then a full drain
      set_idling(0, 0);
      hold_req <= hold_req + 1;
      send_random_readings(PRESSURE_ITEMS);
      in_valid <= 1'b0;
      do @(negedge clk); while (pending_classes.size() != 0);
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending_classes.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_classes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
